// ===== sv/assert_macros.svh =====
// Assertion macros shared by the text pane RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text pane assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text pane assertion failed");

`endif

// ===== sv/tpcs_pkg.sv =====
// Shared types and constants of the text pane.
`default_nettype none

package tpcs_pkg;

  // Field widths of the command and result words.
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 6;
  localparam int CELL_W     = 8;
  localparam int OCOL_W     = 7;
  localparam int OLINE_W    = 5;
  localparam int OUSED_W    = 6;

  // Configuration registers.
  localparam int CFG_COLS_W = 7;
  localparam int CFG_ROWS_W = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 7'd64;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 6'd32;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Character codes with special meaning.
  localparam logic [CODE_W-1:0] CH_BS       = 8'd8;
  localparam logic [CODE_W-1:0] CH_LF       = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR       = 8'd13;
  localparam logic [CODE_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CODE_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CODE_W-1:0] CH_DEL      = 8'd127;

  // Request from the control FSM to the store walker.
  typedef struct packed {
    logic start;
    logic clear;
  } sweep_cmd_t;

endpackage

`default_nettype wire

// ===== sv/tpcs_cmd_if.sv =====
// Command channel of the text pane: valid/ready plus the command word.
`default_nettype none

interface tpcs_cmd_if;
  import tpcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] char_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source(output valid, kind, char_code, read_row, read_col, input ready);
  modport sink(input valid, kind, char_code, read_row, read_col, output ready);
endinterface

`default_nettype wire

// ===== sv/tpcs_res_if.sv =====
// Result channel of the text pane: valid/ready plus the result word.
`default_nettype none

interface tpcs_res_if;
  import tpcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_char;
  logic [OCOL_W-1:0]  cursor_column;
  logic [OLINE_W-1:0] cursor_line;
  logic [OUSED_W-1:0] lines_used;
  logic               scrolled;

  modport source(output valid, cell_char, cursor_column, cursor_line, lines_used,
                 scrolled, input ready);
  modport sink(input valid, cell_char, cursor_column, cursor_line, lines_used,
               scrolled, output ready);
endinterface

`default_nettype wire

// ===== sv/tpcs_cell_ram.sv =====
// Character cell store: one write port, one read port, registered read data.
`default_nettype none

module tpcs_cell_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/tpcs_sweep.sv =====
// Store walker: scrolls the configured rows up by one row, or zeroes the whole store.
`default_nettype none

module tpcs_sweep #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tpcs_pkg::sweep_cmd_t                 cmd,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]        rows,
  input  wire logic [tpcs_pkg::CELL_W-1:0]          rd_data,
  output logic      [$clog2(MAX_ROWS*MAX_COLS)-1:0] rd_addr,
  output logic                                      wr_en,
  output logic      [$clog2(MAX_ROWS*MAX_COLS)-1:0] wr_addr,
  output logic      [tpcs_pkg::CELL_W-1:0]          wr_data,
  output logic                                      done
);
  import tpcs_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW:0] COLS_X  = (AW+1)'(MAX_COLS);
  localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

  logic          active;
  logic [AW:0]   c;
  logic [AW:0]   c_inc;
  logic [AW:0]   copy_end;
  logic [AW:0]   total_end;
  logic          pw_valid;
  logic [AW-1:0] pw_addr;
  logic          pw_zero;

  assign c_inc = c + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pw_valid <= 1'b0;
    end else begin
      pw_valid <= active;
      if (cmd.start) begin
        active <= 1'b1;
      end else if (active && c_inc == total_end) begin
        active <= 1'b0;
      end
    end
  end

  // Cell c of the destination takes cell c plus one row, read in the cycle before the write.
  // Past the copy span the cells are zeroed.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      c         <= '0;
      copy_end  <= cmd.clear ? '0 : (AW+1)'(rows - 1'b1) * COLS_X;
      total_end <= cmd.clear ? DEPTH_X : (AW+1)'(rows) * COLS_X;
    end else if (active) begin
      c <= c_inc;
    end
    pw_addr <= AW'(c);
    pw_zero <= (c >= copy_end);
  end

  assign rd_addr = (c < copy_end) ? AW'(c + COLS_X) : '0;
  assign wr_en   = pw_valid;
  assign wr_addr = pw_addr;
  assign wr_data = pw_zero ? '0 : rd_data;
  assign done    = pw_valid && !active;

endmodule

`default_nettype wire

// ===== sv/text_pane_cursor_scroll_unit.sv =====
// Text pane top level: command decode, cursor state, cell store and store walker.
// Sequence: an accepted word passes S_EXEC, then S_READ for an in-range cell read or
// S_SWEEP for a scrolling put or a clear, then S_DONE, which loads the result register.
// One word is worked on at a time, as cmd.ready is high only in S_IDLE; the walker's single
// write per cycle through the cell store sets the length of scroll and clear.
// Reset: synchronous; a clearing pass zeroes the store, with cmd.ready low until it
// ends; configuration writes are taken throughout.
`default_nettype none
`include "assert_macros.svh"

module text_pane_cursor_scroll_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tpcs_cmd_if.sink                             cmd,
  tpcs_res_if.source                           res,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tpcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpcs_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CW1   = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RW1   = $clog2(MAX_ROWS + 1);
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

  typedef enum logic [2:0] {
    S_INIT, S_INITW, S_IDLE, S_EXEC, S_READ, S_SWEEP, S_DONE
  } state_t;

  state_t state;

  // Configuration as written, and the counts actually used.
  logic [CFG_COLS_W-1:0] cols_raw;
  logic [CFG_ROWS_W-1:0] rows_raw;
  logic [CW1-1:0]        cols_eff;
  logic [RW1-1:0]        rows_eff;

  // Cursor state. The stored row always lies inside the store; the high-water
  // mark can reach MAX_ROWS because it is taken before the scroll pulls back.
  logic [CW-1:0]  cur_col;
  logic [RW-1:0]  cur_row;
  logic [RW1-1:0] high_row;

  // The command word held while it is worked on.
  logic [KIND_W-1:0] it_kind;
  logic [CODE_W-1:0] it_code;
  logic [RROW_W-1:0] it_row;
  logic [RCOL_W-1:0] it_col;

  // Result word register, which lets the result wait while the next word arrives.
  logic               out_valid;
  logic [CELL_W-1:0]  out_cell;
  logic [OCOL_W-1:0]  out_col;
  logic [OLINE_W-1:0] out_line;
  logic [OUSED_W-1:0] out_used;
  logic               out_scr;
  logic [CELL_W-1:0]  res_cell;
  logic               res_scr;

  // Put-character step, worked out from the held word and the cursor.
  logic [CW-1:0]     col_n;
  logic [RW-1:0]     row_n;
  logic [RW1-1:0]    row_s;
  logic [RW1-1:0]    high_n;
  logic [CW1-1:0]    col_inc;
  logic              scr;
  logic              put_we;
  logic [CW-1:0]     put_col;
  logic [CELL_W-1:0] put_data;
  logic [AW-1:0]     put_addr;
  logic              read_ok;
  logic [AW-1:0]     read_addr;

  // Cell store and walker connections.
  sweep_cmd_t        sw_cmd;
  logic [AW-1:0]     sw_rd_addr;
  logic              sw_wr_en;
  logic [AW-1:0]     sw_wr_addr;
  logic [CELL_W-1:0] sw_wr_data;
  logic              sw_done;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // A count of zero behaves as one; counts beyond the store saturate.
  always_comb begin
    if (cols_raw == '0) begin
      cols_eff = CW1'(1);
    end else if (32'(cols_raw) > MAX_COLS) begin
      cols_eff = CW1'(MAX_COLS);
    end else begin
      cols_eff = CW1'(cols_raw);
    end
    if (rows_raw == '0) begin
      rows_eff = RW1'(1);
    end else if (32'(rows_raw) > MAX_ROWS) begin
      rows_eff = RW1'(MAX_ROWS);
    end else begin
      rows_eff = RW1'(rows_raw);
    end
  end

  // Cursor movement. Backspace and delete step left and blank the cell, line
  // feed opens a new row, carriage return homes the column, and printable
  // bytes are stored and advance with wrap. Other bytes only run the row
  // record and the scroll check.
  always_comb begin
    col_n    = cur_col;
    row_s    = RW1'(cur_row);
    put_we   = 1'b0;
    put_col  = cur_col;
    put_data = CH_SPACE;
    col_inc  = CW1'(cur_col) + CW1'(1);
    if (it_code == CH_BS || it_code == CH_DEL) begin
      if (cur_col != '0) begin
        col_n   = cur_col - CW'(1);
        put_col = cur_col - CW'(1);
        put_we  = 1'b1;
      end
    end else if (it_code == CH_LF) begin
      col_n = '0;
      row_s = RW1'(cur_row) + RW1'(1);
    end else if (it_code == CH_CR) begin
      col_n = '0;
    end else if (it_code >= CH_PRINT_LO && !it_code[CODE_W-1]) begin
      put_we   = 1'b1;
      put_data = it_code;
      if (col_inc >= cols_eff) begin
        col_n = '0;
        row_s = RW1'(cur_row) + RW1'(1);
      end else begin
        col_n = CW'(col_inc);
      end
    end
    high_n = (row_s > high_row) ? row_s : high_row;
    scr    = (row_s >= rows_eff);
    row_n  = scr ? RW'(rows_eff - RW1'(1)) : RW'(row_s);
    if (scr) begin
      col_n = '0;
    end
    put_addr = AW'(cur_row) * COLS_A + AW'(put_col);
  end

  assign read_ok   = (32'(it_row) < MAX_ROWS) && (32'(it_col) < MAX_COLS);
  assign read_addr = AW'(it_row) * COLS_A + AW'(it_col);

  // Walker starts: the clearing pass after reset, a clear command, or a scroll.
  assign sw_cmd.start = (state == S_INIT) ||
                        (state == S_EXEC && ((it_kind == KIND_PUT && scr) ||
                                             it_kind == KIND_CLEAR));
  assign sw_cmd.clear = (state == S_INIT) || (it_kind == KIND_CLEAR);

  // The store has one writer at a time: the put step in S_EXEC, or the walker.
  assign ram_we    = (state == S_EXEC && it_kind == KIND_PUT && put_we) || sw_wr_en;
  assign ram_waddr = sw_wr_en ? sw_wr_addr : put_addr;
  assign ram_wdata = sw_wr_en ? sw_wr_data : put_data;
  assign ram_raddr = (state == S_EXEC) ? read_addr : sw_rd_addr;

  tpcs_cell_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (CELL_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tpcs_sweep #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_sweep (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sw_cmd),
    .rows   (rows_eff),
    .rd_data(ram_rdata),
    .rd_addr(sw_rd_addr),
    .wr_en  (sw_wr_en),
    .wr_addr(sw_wr_addr),
    .wr_data(sw_wr_data),
    .done   (sw_done)
  );

  // Control sequence: accept a word, execute it, wait on the store where
  // needed, then hand the result word to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      high_row  <= '0;
      cols_raw  <= COLS_RESET;
      rows_raw  <= ROWS_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COLS: cols_raw <= cfg_data;
          REG_ROWS: rows_raw <= cfg_data[CFG_ROWS_W-1:0];
          default: ;
        endcase
      end
      // In S_DONE the hand-off below decides the next valid on its own.
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          state <= S_INITW;
        end
        S_INITW: begin
          if (sw_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            it_kind <= cmd.kind;
            it_code <= cmd.char_code;
            it_row  <= cmd.read_row;
            it_col  <= cmd.read_col;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_cell <= '0;
          res_scr  <= (it_kind == KIND_PUT) && scr;
          case (it_kind)
            KIND_PUT: begin
              cur_col  <= col_n;
              cur_row  <= row_n;
              high_row <= high_n;
              state    <= scr ? S_SWEEP : S_DONE;
            end
            KIND_READ: begin
              state <= read_ok ? S_READ : S_DONE;
            end
            KIND_CLEAR: begin
              cur_col  <= '0;
              cur_row  <= '0;
              high_row <= '0;
              state    <= S_SWEEP;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          res_cell <= ram_rdata;
          state    <= S_DONE;
        end
        S_SWEEP: begin
          if (sw_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_cell  <= res_cell;
            out_col   <= OCOL_W'(cur_col);
            out_line  <= OLINE_W'(cur_row);
            out_used  <= OUSED_W'(high_row);
            out_scr   <= res_scr;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready         = (state == S_IDLE);
  assign res.valid         = out_valid;
  assign res.cell_char     = out_cell;
  assign res.cursor_column = out_col;
  assign res.cursor_line   = out_line;
  assign res.lines_used    = out_used;
  assign res.scrolled      = out_scr;

  // The cursor never leaves the store once a step has finished.
  `TPCS_ASSERT_NOW(a_cursor_in_store, 1'b1,
                   32'(cur_row) < MAX_ROWS && 32'(cur_col) < MAX_COLS)
  // A result word appears only out of the hand-off state.
  `TPCS_ASSERT_NEXT(a_result_from_done, !out_valid && state != S_DONE, !out_valid)
  // The walker finishes only while the controller waits on it.
  `TPCS_ASSERT_NOW(a_done_when_walking, sw_done, state == S_SWEEP || state == S_INITW)

endmodule

`default_nettype wire
